/* rtl/modbus_rtu_reply_checker_top_assert.svh */
// Assertion macros for the Modbus RTU reply checker.
// Used by the port checker; no other dependencies.
`ifndef MODBUS_RTU_REPLY_CHECKER_TOP_ASSERT_SVH
`define MODBUS_RTU_REPLY_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define MRRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled in reset.
`define MRRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mrrc_pkg.sv */
// Shared types, codes and the CRC-16 helper of the Modbus RTU reply checker.
// No dependencies.
package mrrc_pkg;

  // Input item opcodes.
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_ARM     = 2'd2;

  // Verdict codes.
  localparam logic [3:0] V_OK         = 4'd0;
  localparam logic [3:0] V_UNEXPECTED = 4'd1;
  localparam logic [3:0] V_ADDR       = 4'd2;
  localparam logic [3:0] V_FUNC       = 4'd3;
  localparam logic [3:0] V_EXC        = 4'd4;
  localparam logic [3:0] V_EXC_CRC    = 4'd5;
  localparam logic [3:0] V_CRC        = 4'd6;
  localparam logic [3:0] V_TIMEOUT    = 4'd7;
  localparam logic [3:0] V_REJECTED   = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEVICE   = 2'd0;
  localparam logic [1:0] REG_FUNCTION = 2'd1;
  localparam logic [1:0] REG_COUNT    = 2'd2;

  // Function codes with a known reply length.
  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FC_WRITE_REG     = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  MIN_REPLY = 8'd5;
  localparam logic [7:0]  ECHO_LEN  = 8'd8;

  // One verdict leaving the decision logic.
  typedef struct packed {
    logic       valid;
    logic [3:0] verdict;
    logic [7:0] exception_code;
    logic [7:0] reply_length;
  } result_t;

  // Folds one byte into a reflected Modbus CRC-16.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/mrrc_engine.sv */
// Transaction state and verdict logic of the Modbus RTU reply checker.
// Depends on mrrc_pkg for codes, the result type and the CRC helper.
module mrrc_engine import mrrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  expected_device,
  input  logic [7:0]  expected_function,
  input  logic [10:0] expected_count,
  output result_t     result
);

  logic        armed, armed_next;
  logic [7:0]  rcount, rcount_next;
  logic [7:0]  exp_len, exp_len_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  fb0, fb0_next, fb1, fb1_next, fb2, fb2_next;
  logic [7:0]  lt0, lt0_next, lt1, lt1_next;
  logic [12:0] arm_len;
  logic        crc_good;
  logic        exc;

  // Reply length implied by the outstanding request.
  always_comb begin
    case (expected_function)
      FC_READ_COILS, FC_READ_DISCRETE:
        arm_len = 13'd5 + (({2'b00, expected_count} + 13'd7) >> 3);
      FC_READ_HOLDING, FC_READ_INPUT:
        arm_len = 13'd5 + {1'b0, expected_count, 1'b0};
      FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS:
        arm_len = {5'd0, ECHO_LEN};
      default:
        arm_len = 13'd0;
    endcase
  end

  // Next state and verdict for the item in the input register.
  always_comb begin
    armed_next   = armed;
    rcount_next  = rcount;
    exp_len_next = exp_len;
    crc_next     = crc;
    fb0_next     = fb0;
    fb1_next     = fb1;
    fb2_next     = fb2;
    lt0_next     = lt0;
    lt1_next     = lt1;
    result       = '0;
    exc          = 1'b0;
    crc_good     = 1'b0;
    case (opcode)
      OP_ARM: begin
        rcount_next = 8'd0;
        crc_next    = CRC_INIT;
        fb0_next    = 8'd0;
        fb1_next    = 8'd0;
        fb2_next    = 8'd0;
        lt0_next    = 8'd0;
        lt1_next    = 8'd0;
        if (arm_len == 13'd0 || arm_len > 13'd255) begin
          armed_next           = 1'b0;
          exp_len_next         = 8'd0;
          result.valid         = 1'b1;
          result.verdict       = V_REJECTED;
        end else begin
          armed_next   = 1'b1;
          exp_len_next = arm_len[7:0];
        end
      end
      OP_TIMEOUT: begin
        if (armed) begin
          armed_next          = 1'b0;
          result.valid        = 1'b1;
          result.verdict      = V_TIMEOUT;
          result.reply_length = rcount;
        end
      end
      OP_BYTE: begin
        if (!armed) begin
          result.valid        = 1'b1;
          result.verdict      = V_UNEXPECTED;
          result.reply_length = 8'd1;
        end else begin
          // The CRC covers all but the two newest bytes.
          if (rcount >= 8'd2) begin
            crc_next = crc16_byte(crc, lt0);
          end
          lt0_next = lt1;
          lt1_next = data_byte;
          if (rcount == 8'd0) fb0_next = data_byte;
          if (rcount == 8'd1) fb1_next = data_byte;
          if (rcount == 8'd2) fb2_next = data_byte;
          if (rcount != 8'hFF) begin
            rcount_next = rcount + 8'd1;
          end
          exc      = fb1_next[7];
          crc_good = ({lt1_next, lt0_next} == crc_next);
          // Decide on a short exception reply or at the full length.
          if (rcount_next >= MIN_REPLY && (exc || rcount_next >= exp_len)) begin
            armed_next          = 1'b0;
            result.valid        = 1'b1;
            result.reply_length = rcount_next;
            if (fb0_next != expected_device) begin
              result.verdict = V_ADDR;
            end else if ({1'b0, fb1_next[6:0]} != expected_function) begin
              result.verdict = V_FUNC;
            end else if (exc) begin
              result.verdict        = crc_good ? V_EXC : V_EXC_CRC;
              result.exception_code = fb2_next;
            end else begin
              result.verdict = crc_good ? V_OK : V_CRC;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed   <= 1'b0;
      rcount  <= 8'd0;
      exp_len <= 8'd0;
      crc     <= CRC_INIT;
      fb0     <= 8'd0;
      fb1     <= 8'd0;
      fb2     <= 8'd0;
      lt0     <= 8'd0;
      lt1     <= 8'd0;
    end else if (step) begin
      armed   <= armed_next;
      rcount  <= rcount_next;
      exp_len <= exp_len_next;
      crc     <= crc_next;
      fb0     <= fb0_next;
      fb1     <= fb1_next;
      fb2     <= fb2_next;
      lt0     <= lt0_next;
      lt1     <= lt1_next;
    end
  end

endmodule

/* rtl/modbus_rtu_reply_checker_top.sv */
// Modbus RTU reply checker top level; depends on mrrc_pkg and mrrc_engine.
// An accepted item waits in the input register; its result is loaded when the item advances.
// Throughput: one item per cycle while the output side keeps taking results;
// the input register and the result register are the two stages.
// Reset (rst, synchronous, active high) disarms, clears both stages and loads
// the configuration defaults: device 1, function 3, count 1.
module modbus_rtu_reply_checker_top import mrrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  verdict,
  output logic [7:0]  exception_code,
  output logic [7:0]  reply_length,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  logic        s_valid;
  logic [1:0]  s_opcode;
  logic [7:0]  s_data;
  logic        adv;
  logic [7:0]  expected_device;
  logic [7:0]  expected_function;
  logic [10:0] expected_count;
  result_t     res;

  // The input register moves on whenever the result register can take its item.
  assign adv      = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_device   <= 8'd1;
      expected_function <= 8'd3;
      expected_count    <= 11'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEVICE:   expected_device   <= cfg_wdata[7:0];
        REG_FUNCTION: expected_function <= cfg_wdata[7:0];
        REG_COUNT:    expected_count    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (adv) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_opcode <= opcode;
      s_data   <= data_byte;
    end
  end

  mrrc_engine u_engine (
    .clk               (clk),
    .rst               (rst),
    .step              (adv),
    .opcode            (s_opcode),
    .data_byte         (s_data),
    .expected_device   (expected_device),
    .expected_function (expected_function),
    .expected_count    (expected_count),
    .result            (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      verdict        <= res.verdict;
      exception_code <= res.exception_code;
      reply_length   <= res.reply_length;
    end
  end

endmodule

/* rtl/mrrc_checker.sv */
// Port-level assertions for the Modbus RTU reply checker, bound to the top.
// Depends on mrrc_pkg and the assertion macro header.
`include "modbus_rtu_reply_checker_top_assert.svh"

module mrrc_checker import mrrc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  opcode,
  input logic [7:0]  data_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  verdict,
  input logic [7:0]  exception_code,
  input logic [7:0]  reply_length
);

  logic [9:0] in_item;
  logic       in_stall;
  logic       out_stall;
  logic       out_code;
  logic       exc_verdict;
  logic       out_rej;
  logic       out_unexp;

  // Conditions the assertions look at.
  assign in_item     = {opcode, data_byte};
  assign in_stall    = in_valid && !in_ready;
  assign out_stall   = out_valid && !out_ready;
  assign out_code    = out_valid && exception_code != 8'd0;
  assign exc_verdict = verdict == V_EXC || verdict == V_EXC_CRC;
  assign out_rej     = out_valid && verdict == V_REJECTED;
  assign out_unexp   = out_valid && verdict == V_UNEXPECTED;

  // A waiting input item stays offered and unchanged.
  `MRRC_ASSERT_NXT(a_in_hold, in_stall, in_valid && $stable(in_item), "waiting item changed")

  // A stalled result keeps its verdict.
  `MRRC_ASSERT_NXT(a_hold, out_stall, out_valid && $stable(verdict), "stalled verdict changed")

  // Only exception verdicts carry an exception code.
  `MRRC_ASSERT_IMP(a_exc, out_code, exc_verdict, "stray exception code")

  // A rejected request reports no bytes, an unexpected byte reports one.
  `MRRC_ASSERT_IMP(a_rej, out_rej, reply_length == 8'd0, "rejected request with a length")
  `MRRC_ASSERT_IMP(a_unexp, out_unexp, reply_length == 8'd1, "unexpected byte with wrong length")

endmodule

bind modbus_rtu_reply_checker_top mrrc_checker u_mrrc_checker (.*);
